/* hw/rtl/assert_macros.svh */
// assertion macros used by the port-level checker
// no dependencies; the including scope provides clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCLS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcls assertion failed");

// antecedent implies consequent in the next cycle
`define PCLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcls assertion failed");

`endif

/* hw/rtl/pcls_pkg.sv */
// types, constants and the builtin name table of the command line splitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcls_pkg;

	typedef logic [7:0] char_t;

	localparam int BUILTIN_COUNT = 28;
	localparam int BUILTIN_LEN   = 8;
	localparam int NAME_POS_W    = $clog2(BUILTIN_LEN);

	typedef logic [BUILTIN_COUNT-1:0] match_t;
	typedef logic [3:0]               pos_t;

	localparam pos_t  POS_MAX        = 4'd15;
	localparam pos_t  NAME_END       = 4'(BUILTIN_LEN);
	localparam char_t MAX_ARGS_RESET = 8'd64;

	// apb byte address of the max_args register
	localparam logic [1:0] REG_MAX_ARGS = 2'd0;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_TAB   = 8'h09;

	typedef struct packed {
		char_t ch;
	} cmd_t;

	typedef struct packed {
		char_t out_char;
		logic  word_start;
		char_t arg_index;
		logic  line_done;
		char_t arg_count;
	} res_t;

	// request from the line state to the name matcher
	typedef struct packed {
		pos_t  pos;
		char_t chr;
	} match_req_t;

	localparam char_t BUILTIN_NAMES [BUILTIN_COUNT][BUILTIN_LEN] = '{
		'{"e", "x", "i", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"e", "x", "e", "c", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"c", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"r", "m", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"[", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"c", "a", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"e", "n", "v", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"p", "w", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"w", "a", "i", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"e", "c", "h", "o", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"r", "e", "a", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"t", "r", "u", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"t", "e", "s", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"k", "i", "l", "l", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"p", "a", "u", "s", "e", CH_NUL, CH_NUL, CH_NUL},
		'{"f", "l", "o", "c", "k", CH_NUL, CH_NUL, CH_NUL},
		'{"c", "h", "m", "o", "d", CH_NUL, CH_NUL, CH_NUL},
		'{"t", "o", "u", "c", "h", CH_NUL, CH_NUL, CH_NUL},
		'{"r", "m", "d", "i", "r", CH_NUL, CH_NUL, CH_NUL},
		'{"m", "k", "d", "i", "r", CH_NUL, CH_NUL, CH_NUL},
		'{"f", "a", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL},
		'{"m", "k", "t", "e", "m", "p", CH_NUL, CH_NUL},
		'{"u", "s", "l", "e", "e", "p", CH_NUL, CH_NUL},
		'{"t", "o", "u", "p", "p", "e", "r", CH_NUL},
		'{"t", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"s", "e", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"a", "w", "k", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"c", "u", "r", "l", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
	};

	function automatic logic is_word_byte(input char_t c);
		logic r;
		r = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
		    ((c >= "0") && (c <= "9")) ||
		    (c == "_") || (c == "-") || (c == ".") || (c == "/") ||
		    (c == ":") || (c == ",") || (c == "+") || (c == "@");
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/pcls_stream_if.sv */
// valid/ready stream channel with a typed payload
// no dependencies; payload type set at instantiation
`timescale 1ns / 1ps
`default_nettype none

interface pcls_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pcls_match.sv */
// builtin name matcher: compares one byte of the first word against every name
// depends on pcls_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcls_match (
	input  wire pcls_pkg::match_t     match_cur,
	input  wire pcls_pkg::match_req_t req,
	output pcls_pkg::match_t          match_next
);
	import pcls_pkg::*;

	logic in_range;

	assign in_range = (req.pos < NAME_END);

	always_comb begin
		for (int i = 0; i < BUILTIN_COUNT; i++) begin
			match_next[i] = match_cur[i] & in_range &
			                (BUILTIN_NAMES[i][req.pos[NAME_POS_W-1:0]] == req.chr);
		end
	end
endmodule

`default_nettype wire

/* hw/rtl/pcls_core.sv */
// line state and per-byte result logic of the command line splitter
// depends on pcls_pkg and pcls_match
`timescale 1ns / 1ps
`default_nettype none

module pcls_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire pcls_pkg::char_t ch,
	input  wire pcls_pkg::char_t max_args,
	output pcls_pkg::res_t       res
);
	import pcls_pkg::*;

	logic       in_word_q, in_word_d;
	char_t      word_count_q, word_count_d;
	logic       rejected_q, rejected_d;
	pos_t       fw_pos_q, fw_pos_d;
	match_t     match_q, match_d;
	logic       fw_ended_q, fw_ended_d;

	match_req_t mreq;
	match_t     match_next;
	logic       is_word;
	logic       is_sep;
	logic       first_open;
	logic       over;
	match_t     final_match;

	assign is_word    = is_word_byte(ch);
	assign is_sep     = (ch == CH_SPACE) || (ch == CH_TAB);
	assign first_open = in_word_q && (word_count_q == 8'd1) && !fw_ended_q;
	assign over       = ({1'b0, word_count_q} + 9'd1) >= {1'b0, max_args};

	assign mreq.pos = fw_pos_q;
	assign mreq.chr = is_word ? ch : CH_NUL;

	pcls_match u_match (
		.match_cur  (match_q),
		.req        (mreq),
		.match_next (match_next)
	);

	always_comb begin
		in_word_d    = in_word_q;
		word_count_d = word_count_q;
		rejected_d   = rejected_q;
		fw_pos_d     = fw_pos_q;
		match_d      = match_q;
		fw_ended_d   = fw_ended_q;
		res          = '0;
		final_match  = first_open ? match_next : match_q;
		priority if (ch == CH_NUL) begin
			res.line_done = 1'b1;
			if (!rejected_q && (word_count_q != 8'd0) && (final_match == '0)) begin
				res.arg_count = word_count_q;
			end
			in_word_d    = 1'b0;
			word_count_d = 8'd0;
			rejected_d   = 1'b0;
			fw_pos_d     = '0;
			match_d      = '1;
			fw_ended_d   = 1'b0;
		end else if (rejected_q) begin
			// consume to end of line
		end else if (is_sep) begin
			if (first_open) begin
				match_d    = match_next;
				fw_ended_d = 1'b1;
			end
			in_word_d = 1'b0;
		end else if (is_word) begin
			if (!in_word_q && over) begin
				rejected_d = 1'b1;
			end else begin
				if (!in_word_q) begin
					res.word_start = 1'b1;
					res.arg_index  = word_count_q;
					word_count_d   = word_count_q + 8'd1;
					in_word_d      = 1'b1;
				end
				res.out_char = ch;
				if ((word_count_d == 8'd1) && !fw_ended_q) begin
					match_d  = match_next;
					fw_pos_d = (fw_pos_q == POS_MAX) ? fw_pos_q : fw_pos_q + 4'd1;
				end
			end
		end else begin
			rejected_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q    <= 1'b0;
			word_count_q <= 8'd0;
			rejected_q   <= 1'b0;
			fw_pos_q     <= '0;
			match_q      <= '1;
			fw_ended_q   <= 1'b0;
		end else if (step) begin
			in_word_q    <= in_word_d;
			word_count_q <= word_count_d;
			rejected_q   <= rejected_d;
			fw_pos_q     <= fw_pos_d;
			match_q      <= match_d;
			fw_ended_q   <= fw_ended_d;
		end
	end
endmodule

`default_nettype wire

/* hw/rtl/pcls_cfg.sv */
// apb register block holding max_args
// depends on pcls_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcls_cfg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [1:0]            paddr,
	input  wire [31:0]           pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output pcls_pkg::char_t      max_args
);
	import pcls_pkg::*;

	char_t max_args_q;
	logic  wr_en;

	// writes to any other address are dropped
	assign wr_en    = psel && penable && pwrite && (paddr == REG_MAX_ARGS);
	assign pready   = 1'b1;
	assign prdata   = {24'd0, max_args_q};
	assign max_args = max_args_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= MAX_ARGS_RESET;
		end else if (wr_en) begin
			max_args_q <= pwdata[7:0];
		end
	end
endmodule

`default_nettype wire

/* hw/rtl/plain_command_line_splitter_unit.sv */
// top level of the command line splitter: input register, line logic, result register
// depends on pcls_pkg, pcls_stream_if, pcls_core, pcls_match and pcls_cfg
//
// usage
// cmd carries one byte of a command line per request (payload.ch); a zero byte
// ends the line. res returns one request per byte: the copied byte (0 at
// separators and line end), a word start mark with its argument index, and on
// the zero byte line_done with the argument count (0 for a rejected, empty or
// builtin line). max_args is written through the apb port at address 0.
// a byte taken from cmd is held in the input register; the line logic works on it and its
// result is registered in the result register, which drives res.
// throughput: one byte per cycle while res is not stalled.
// a byte is taken while a result waits, as long as the input register is empty.
// reset empties both pipeline stages, clears the line state and sets max_args
// to 64.
// when res stalls the result holds, the input register fills, then cmd.ready
// drops until res.ready returns.
`timescale 1ns / 1ps
`default_nettype none

module plain_command_line_splitter_unit (
	input  wire         clk,
	input  wire         arst_n,
	pcls_stream_if.sink   cmd,
	pcls_stream_if.source res,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [1:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcls_pkg::*;

	logic  valid_s1;
	char_t ch_s1;
	logic  valid_s2;
	res_t  res_s2;

	logic  adv2;
	logic  adv1;
	char_t max_args;
	res_t  res_comb;

	assign adv2      = !valid_s2 || res.ready;
	assign adv1      = valid_s1 && adv2;
	assign cmd.ready = !valid_s1 || adv2;

	pcls_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.max_args (max_args)
	);

	pcls_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv1),
		.ch       (ch_s1),
		.max_args (max_args),
		.res      (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			ch_s1 <= cmd.payload.ch;
		end
		if (adv1) begin
			res_s2 <= res_comb;
		end
	end

	assign res.valid   = valid_s2;
	assign res.payload = res_s2;
endmodule

`default_nettype wire

/* hw/rtl/pcls_checker.sv */
// port-level checker for the command line splitter, bound to the top level
// depends on pcls_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pcls_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 res_valid,
	input wire                 res_ready,
	input wire pcls_pkg::res_t res_payload
);
	import pcls_pkg::*;

	`PCLS_ASSERT_SAME(a_start_has_char, res_valid && res_payload.word_start, res_payload.out_char != CH_NUL)
	`PCLS_ASSERT_SAME(a_done_is_quiet, res_valid && res_payload.line_done, (res_payload.out_char == CH_NUL) && !res_payload.word_start)
	`PCLS_ASSERT_SAME(a_count_only_at_end, res_valid && !res_payload.line_done, res_payload.arg_count == 8'd0)
	`PCLS_ASSERT_NEXT(a_stall_holds, res_valid && !res_ready, res_valid && $stable(res_payload))
endmodule

bind plain_command_line_splitter_unit pcls_checker u_pcls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);

`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for the command line splitter: directed lines, random lines, backpressure
// depends on pcls_pkg, pcls_stream_if and plain_command_line_splitter_unit
// results are predicted per byte and checked in order against the res channel
`timescale 1ns / 1ps

module testbench;
	import pcls_pkg::*;

	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          HOLD_CYCLES  = 200;
	localparam int          SETTLE_TICKS = 4;
	localparam logic [1:0]  REG_SPARE    = 2'd1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pcls_stream_if #(.payload_t(cmd_t)) cmd_ch ();
	pcls_stream_if #(.payload_t(res_t)) res_ch ();

	plain_command_line_splitter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	char_t  cfg_max_args;
	logic   in_word_q;
	int     word_total;
	logic   line_rejected;
	pos_t   name_pos;
	match_t name_hits;
	logic   first_done;

	res_t   expected_results [$];
	int     fail_count  = 0;
	int     items_sent  = 0;
	int     cycle_count = 0;
	bit     idle_on     = 1'b1;
	bit     hold_req    = 1'b0;
	int     sink_stall  = 0;
	string  word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-./:,+@";

	function automatic void clear_line();
		in_word_q     = 1'b0;
		word_total    = 0;
		line_rejected = 1'b0;
		name_pos      = '0;
		name_hits     = '1;
		first_done    = 1'b0;
	endfunction

	function automatic logic word_char(input char_t c);
		case (c)
			"_", "-", ".", "/", ":", ",", "+", "@": return 1'b1;
			default: return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
				((c >= "0") && (c <= "9"));
		endcase
	endfunction

	// one byte of the first word against every name at once
	function automatic void match_step(input char_t c);
		int p;
		p = int'(name_pos);
		for (int i = 0; i < BUILTIN_COUNT; i++) begin
			if (!((p < BUILTIN_LEN) && (BUILTIN_NAMES[i][p] == c)))
				name_hits[i] = 1'b0;
		end
	endfunction

	function automatic void close_word();
		if (in_word_q && (word_total == 1) && !first_done) begin
			match_step(CH_NUL);
			first_done = 1'b1;
		end
		in_word_q = 1'b0;
	endfunction

	function automatic res_t split_byte(input char_t c);
		res_t r;
		r = '0;
		if (c == CH_NUL) begin
			if (!line_rejected)
				close_word();
			r.line_done = 1'b1;
			if (!line_rejected && (word_total != 0) && (name_hits == '0))
				r.arg_count = char_t'(word_total);
			clear_line();
		end else if (line_rejected) begin
			r = '0;
		end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
			close_word();
		end else if (word_char(c)) begin
			if (!in_word_q) begin
				if (word_total + 1 >= int'(cfg_max_args)) begin
					line_rejected = 1'b1;
				end else begin
					r.word_start = 1'b1;
					r.arg_index  = char_t'(word_total);
					word_total++;
					in_word_q = 1'b1;
				end
			end
			if (!line_rejected) begin
				r.out_char = c;
				if ((word_total == 1) && !first_done) begin
					match_step(c);
					if (name_pos < POS_MAX)
						name_pos++;
				end
			end
		end else begin
			line_rejected = 1'b1;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic char_t pick_sep();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic char_t pick_word_char();
		return char_t'(word_chars[$urandom_range(0, word_chars.len() - 1)]);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			expected_results.push_back(split_byte(cmd_ch.payload.ch));
	end

	task automatic note_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected request, expected none actual %h", $time, got);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				note_field("out_char", int'(want.out_char), int'(got.out_char));
				note_field("word_start", int'(want.word_start), int'(got.word_start));
				note_field("arg_index", int'(want.arg_index), int'(got.arg_index));
				note_field("line_done", int'(want.line_done), int'(got.line_done));
				note_field("arg_count", int'(want.arg_count), int'(got.arg_count));
			end
		end
	end

	// sink side: random stalls, or one long hold when asked
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (sink_stall > 0) begin
				res_ch.ready <= 1'b0;
				sink_stall--;
			end else begin
				res_ch.ready <= 1'b1;
				sink_stall = pick_gap();
			end
		end
	end

	task automatic send_byte(input char_t c);
		int gap;
		@(negedge clk);
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= '{ch: c};
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(char_t'(s[i]));
		send_byte(CH_NUL);
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (a == REG_MAX_ARGS)
			cfg_max_args = d[7:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input logic [1:0] a, output logic [31:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_max_args(input char_t v);
		logic [31:0] rd;
		settle();
		apb_write(REG_MAX_ARGS, {24'($urandom_range(0, 16777215)), v});
		apb_read(REG_MAX_ARGS, rd);
		if (rd[7:0] != cfg_max_args) begin
			$display("%0t: max_args readback expected %0h actual %0h", $time, cfg_max_args,
				rd[7:0]);
			fail_count++;
		end
	endtask

	task automatic send_random_line(input int max_words);
		char_t line [$];
		int    words;
		int    kind;
		int    len;
		int    k;
		int    j;
		if ($urandom_range(0, 19) == 0) begin
			// raw noise line
			len = $urandom_range(1, 10);
			repeat (len) line.push_back(char_t'($urandom_range(1, 255)));
		end else begin
			if ($urandom_range(0, 4) == 0)
				line.push_back(pick_sep());
			words = $urandom_range(0, max_words);
			for (int w = 0; w < words; w++) begin
				if (w > 0)
					repeat ($urandom_range(1, 2)) line.push_back(pick_sep());
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					k = $urandom_range(0, BUILTIN_COUNT - 1);
					j = 0;
					while ((j < BUILTIN_LEN) && (BUILTIN_NAMES[k][j] != CH_NUL)) begin
						line.push_back(BUILTIN_NAMES[k][j]);
						j++;
					end
					// near misses: one byte too many or too few
					if (kind < 8)
						line.push_back(pick_word_char());
					else if ((kind < 12) && (j > 1))
						void'(line.pop_back());
				end else begin
					len = (kind >= 95) ? $urandom_range(9, 20) : $urandom_range(1, 8);
					repeat (len) line.push_back(pick_word_char());
				end
			end
			if ($urandom_range(0, 4) == 0)
				line.push_back(pick_sep());
			if (($urandom_range(0, 9) == 0) && (line.size() > 0))
				line[$urandom_range(0, line.size() - 1)] = char_t'($urandom_range(1, 255));
		end
		foreach (line[i])
			send_byte(line[i]);
		send_byte(CH_NUL);
	endtask

	task automatic run_lines(input int budget, input int max_words);
		int start;
		start = items_sent;
		while (items_sent - start < budget)
			send_random_line(max_words);
	endtask

	task automatic test_empty_and_builtin();
		send_line("");
		send_line("cd x");
	endtask

	task automatic test_separators_and_reject();
		send_line("\t@Z9 ~x");
		send_byte("a");
		send_byte(8'hff);
		send_byte(CH_NUL);
	endtask

	task automatic test_small_max_args();
		set_max_args(8'd1);
		send_line("a");
		set_max_args(8'd0);
		send_line("b c");
		set_max_args(8'd2);
		send_line("x y");
	endtask

	task automatic test_spare_register();
		logic [31:0] rd;
		settle();
		apb_write(REG_SPARE, 32'h0000_0003);
		apb_read(REG_MAX_ARGS, rd);
		if (rd[7:0] != cfg_max_args) begin
			$display("%0t: max_args after spare write expected %0h actual %0h", $time,
				cfg_max_args, rd[7:0]);
			fail_count++;
		end
		send_line("p q r s");
	endtask

	task automatic test_random_lines();
		set_max_args(MAX_ARGS_RESET);
		run_lines(130, 8);
		set_max_args(char_t'($urandom_range(2, 6)));
		run_lines(100, 7);
		set_max_args(8'd255);
		idle_on = 1'b0;
		run_lines(90, 8);
		idle_on = 1'b1;
		set_max_args(8'd0);
		run_lines(30, 4);
		set_max_args(8'd1);
		run_lines(30, 4);
		set_max_args(8'd64);
		run_lines(120, 8);
	endtask

	task automatic test_backpressure();
		settle();
		idle_on  = 1'b0;
		hold_req = 1'b1;
		send_line("hold the line while the sink waits");
		idle_on = 1'b1;
		settle();
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.payload = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		cfg_max_args   = MAX_ARGS_RESET;
		clear_line();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_builtin();
		test_separators_and_reject();
		test_small_max_args();
		test_spare_register();
		test_random_lines();
		test_backpressure();

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
